[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Every macro expects signals named clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

[rtl/dpbp_pkg.sv]
// Package for the depth pixel back-projection block: widths, reset values,
// register indexes and the divider payload type. No dependencies.
package dpbp_pkg;

	// field widths
	localparam int PIX_W      = 12;
	localparam int REG_W      = 20;
	localparam int DEPTH_W    = 20;
	localparam int FRAC_SHIFT = 8;
	localparam int OFF_W      = PIX_W + FRAC_SHIFT + 1;
	localparam int PROD_W     = OFF_W + DEPTH_W;
	localparam int MAG_W      = PROD_W - 1;
	localparam int QUO_W      = 24;
	localparam int HI_W       = MAG_W - QUO_W;
	localparam int OUT_W      = 24;
	localparam int CFG_IDX_W  = 8;

	// stream widths, padded to whole bytes
	localparam int S_DATA_W   = ((2 * PIX_W + DEPTH_W + 7) / 8) * 8;
	localparam int M_DATA_W   = ((2 * OUT_W + DEPTH_W + 7) / 8) * 8;

	// divider: quotient bits resolved per stage
	localparam int DIV_BITS   = 4;

	// register reset values
	localparam logic [REG_W-1:0] FOCAL_X_RST  = REG_W'(256000);
	localparam logic [REG_W-1:0] FOCAL_Y_RST  = REG_W'(256000);
	localparam logic [REG_W-1:0] CENTER_X_RST = REG_W'(163840);
	localparam logic [REG_W-1:0] CENTER_Y_RST = REG_W'(122880);

	// saturation limits
	localparam logic [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_NEG_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCAL_X  = 8'd0,
		REG_FOCAL_Y  = 8'd1,
		REG_CENTER_X = 8'd2,
		REG_CENTER_Y = 8'd3
	} reg_idx_t;

	// one axis in flight through the divider
	typedef struct packed {
		logic             neg;   // numerator negative
		logic             ovf;   // quotient magnitude at least 2**QUO_W
		logic [REG_W-1:0] rem;   // partial remainder
		logic [QUO_W-1:0] dvd;   // dividend bits not yet consumed, MSB first
		logic [QUO_W-1:0] quo;   // quotient bits so far
	} div_t;

endpackage

[rtl/dpbp_axis_prep.sv]
// One axis front end: offset from the principal point, product with depth,
// then magnitude, sign and overflow check. Uses dpbp_pkg.
module dpbp_axis_prep (
	input  logic                         clk,
	input  logic                         en_s1,
	input  logic                         en_s2,
	input  logic                         en_s3,
	input  logic [dpbp_pkg::PIX_W-1:0]   pix,
	input  logic [dpbp_pkg::REG_W-1:0]   center,
	input  logic [dpbp_pkg::DEPTH_W-1:0] depth_s1,
	input  logic [dpbp_pkg::REG_W-1:0]   focal,
	output dpbp_pkg::div_t               div_s3
);

	logic signed [dpbp_pkg::OFF_W-1:0]    off_s1;
	logic signed [dpbp_pkg::PROD_W-1:0]   prod_s2;
	logic signed [dpbp_pkg::PROD_W:0]     prod_full;
	logic        [dpbp_pkg::PROD_W-1:0]   prod_neg;
	logic        [dpbp_pkg::MAG_W-1:0]    mag;
	logic        [dpbp_pkg::HI_W-1:0]     mag_hi;
	logic                                 ovf;

	// stage 1: signed Q.8 offset
	always_ff @(posedge clk) begin
		if (en_s1) begin
			off_s1 <= $signed({1'b0, pix, {dpbp_pkg::FRAC_SHIFT{1'b0}}})
				- $signed({1'b0, center});
		end
	end

	// stage 2: numerator, signed Q.8
	always_comb begin
		prod_full = off_s1 * $signed({1'b0, depth_s1});
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_s2 <= prod_full[dpbp_pkg::PROD_W-1:0];
		end
	end

	// stage 3: magnitude; quotient overflows when the top bits reach the divisor
	always_comb begin
		prod_neg = dpbp_pkg::PROD_W'(-prod_s2);
		mag = prod_s2[dpbp_pkg::PROD_W-1] ? prod_neg[dpbp_pkg::MAG_W-1:0]
			: prod_s2[dpbp_pkg::MAG_W-1:0];
		mag_hi = mag[dpbp_pkg::MAG_W-1:dpbp_pkg::QUO_W];
		ovf = ({{(dpbp_pkg::REG_W-dpbp_pkg::HI_W){1'b0}}, mag_hi} >= focal)
			&& (mag != '0);
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			div_s3.neg <= prod_s2[dpbp_pkg::PROD_W-1];
			div_s3.ovf <= ovf;
			div_s3.rem <= {{(dpbp_pkg::REG_W-dpbp_pkg::HI_W){1'b0}}, mag_hi};
			div_s3.dvd <= mag[dpbp_pkg::QUO_W-1:0];
			div_s3.quo <= '0;
		end
	end

endmodule

[rtl/dpbp_div_stage.sv]
// One registered stage of the restoring divider: BITS quotient bits per stage.
// Uses dpbp_pkg::div_t.
module dpbp_div_stage #(
	parameter int BITS = dpbp_pkg::DIV_BITS
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [dpbp_pkg::REG_W-1:0] focal,
	input  dpbp_pkg::div_t             d_in,
	output dpbp_pkg::div_t             d_out
);

	dpbp_pkg::div_t d_nxt;

	// shift in one dividend bit, subtract the divisor when it fits;
	// a zero divisor never fits, so a zero numerator keeps a zero quotient
	always_comb begin
		logic [dpbp_pkg::REG_W:0] trial;
		logic                     ge;
		d_nxt = d_in;
		for (int i = 0; i < BITS; i++) begin
			trial = {d_nxt.rem, d_nxt.dvd[dpbp_pkg::QUO_W-1]};
			ge = (focal != '0) && (trial >= {1'b0, focal});
			trial = ge ? (trial - {1'b0, focal}) : trial;
			d_nxt.rem = trial[dpbp_pkg::REG_W-1:0];
			d_nxt.dvd = {d_nxt.dvd[dpbp_pkg::QUO_W-2:0], 1'b0};
			d_nxt.quo = {d_nxt.quo[dpbp_pkg::QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= d_nxt;
		end
	end

endmodule

[rtl/depth_pixel_back_projection.sv]
// Depth pixel back-projection: depth pixel to camera-space point (x, y, z).
// Pipeline: offset, multiply, magnitude, one stage per DIV_BITS quotient
// bits, saturation/output register.
// Throughput: one item per cycle; every stage holds under output backpressure.
// Reset (arst_n low, asynchronous): pipeline emptied, registers at defaults.
module depth_pixel_back_projection #(
	parameter int DIV_BITS = dpbp_pkg::DIV_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input items
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dpbp_pkg::S_DATA_W-1:0]   s_tdata,   // pixel_column, pixel_row, depth_mm, pad
	// result items
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dpbp_pkg::M_DATA_W-1:0]   m_tdata,   // point_x, point_y, point_z, pad
	output logic [0:0]                      m_tuser,   // clipped
	// register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dpbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dpbp_pkg::REG_W-1:0]      cfg_data
);

	localparam int NDIV = dpbp_pkg::QUO_W / DIV_BITS;
	localparam int NST  = NDIV + 4;

	logic [dpbp_pkg::REG_W-1:0]   focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [NST-1:0]               v_q;
	logic [NST-1:0]               en;
	logic [dpbp_pkg::PIX_W-1:0]   col_in, row_in;
	logic [dpbp_pkg::DEPTH_W-1:0] depth_in;
	logic [dpbp_pkg::DEPTH_W-1:0] z_s [NST];
	dpbp_pkg::div_t               dx_s [NDIV+1];
	dpbp_pkg::div_t               dy_s [NDIV+1];
	logic [dpbp_pkg::OUT_W:0]     sat_x, sat_y;
	logic [dpbp_pkg::OUT_W-1:0]   out_x_q, out_y_q;
	logic                         out_clip_q;

	assign col_in   = s_tdata[dpbp_pkg::PIX_W-1:0];
	assign row_in   = s_tdata[2*dpbp_pkg::PIX_W-1:dpbp_pkg::PIX_W];
	assign depth_in = s_tdata[2*dpbp_pkg::PIX_W+dpbp_pkg::DEPTH_W-1:2*dpbp_pkg::PIX_W];

	// register writes, always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= dpbp_pkg::FOCAL_X_RST;
			focal_y_q  <= dpbp_pkg::FOCAL_Y_RST;
			center_x_q <= dpbp_pkg::CENTER_X_RST;
			center_y_q <= dpbp_pkg::CENTER_Y_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				dpbp_pkg::REG_FOCAL_X:  focal_x_q  <= cfg_data;
				dpbp_pkg::REG_FOCAL_Y:  focal_y_q  <= cfg_data;
				dpbp_pkg::REG_CENTER_X: center_x_q <= cfg_data;
				dpbp_pkg::REG_CENTER_Y: center_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when empty or when the next one moves
	assign en[NST-1] = !v_q[NST-1] || m_tready;
	for (genvar k = 0; k < NST - 1; k++) begin : g_en
		assign en[k] = !v_q[k] || en[k+1];
	end
	assign s_tready = en[0];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	// depth rides along as point_z
	always_ff @(posedge clk) begin
		if (en[0]) begin
			z_s[0] <= depth_in;
		end
		for (int k = 1; k < NST; k++) begin
			if (en[k]) begin
				z_s[k] <= z_s[k-1];
			end
		end
	end

	// offset, product, magnitude per axis
	dpbp_axis_prep u_prep_x (
		.clk      (clk),
		.en_s1    (en[0]),
		.en_s2    (en[1]),
		.en_s3    (en[2]),
		.pix      (col_in),
		.center   (center_x_q),
		.depth_s1 (z_s[0]),
		.focal    (focal_x_q),
		.div_s3   (dx_s[0])
	);

	dpbp_axis_prep u_prep_y (
		.clk      (clk),
		.en_s1    (en[0]),
		.en_s2    (en[1]),
		.en_s3    (en[2]),
		.pix      (row_in),
		.center   (center_y_q),
		.depth_s1 (z_s[0]),
		.focal    (focal_y_q),
		.div_s3   (dy_s[0])
	);

	// divider stages
	for (genvar k = 0; k < NDIV; k++) begin : g_div
		dpbp_div_stage #(.BITS(DIV_BITS)) u_div_x (
			.clk   (clk),
			.en    (en[k+3]),
			.focal (focal_x_q),
			.d_in  (dx_s[k]),
			.d_out (dx_s[k+1])
		);

		dpbp_div_stage #(.BITS(DIV_BITS)) u_div_y (
			.clk   (clk),
			.en    (en[k+3]),
			.focal (focal_y_q),
			.d_in  (dy_s[k]),
			.d_out (dy_s[k+1])
		);
	end

	// sign and saturation: returns {clipped, value}
	function automatic logic [dpbp_pkg::OUT_W:0] sat_axis(input dpbp_pkg::div_t d);
		logic                       big;
		logic [dpbp_pkg::OUT_W-1:0] neg_q;
		big   = d.quo[dpbp_pkg::QUO_W-1] && (d.quo[dpbp_pkg::QUO_W-2:0] != '0);
		neg_q = dpbp_pkg::OUT_W'(-d.quo);
		if (!d.neg) begin
			if (d.ovf || d.quo[dpbp_pkg::QUO_W-1]) begin
				return {1'b1, dpbp_pkg::OUT_POS_MAX};
			end
			return {1'b0, d.quo};
		end
		if (d.ovf || big) begin
			return {1'b1, dpbp_pkg::OUT_NEG_MIN};
		end
		return {1'b0, neg_q};
	endfunction

	always_comb begin
		sat_x = sat_axis(dx_s[NDIV]);
		sat_y = sat_axis(dy_s[NDIV]);
	end

	// output register
	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			out_x_q    <= sat_x[dpbp_pkg::OUT_W-1:0];
			out_y_q    <= sat_y[dpbp_pkg::OUT_W-1:0];
			out_clip_q <= sat_x[dpbp_pkg::OUT_W] || sat_y[dpbp_pkg::OUT_W];
		end
	end

	assign m_tvalid = v_q[NST-1];
	assign m_tdata  = {{(dpbp_pkg::M_DATA_W-2*dpbp_pkg::OUT_W-dpbp_pkg::DEPTH_W){1'b0}},
		z_s[NST-1], out_y_q, out_x_q};
	assign m_tuser  = out_clip_q;

endmodule

[rtl/dpbp_checker.sv]
// Port-level checks for depth_pixel_back_projection, bound to the top level.
// Depends on assert_macros.svh and dpbp_pkg.
`include "assert_macros.svh"

module dpbp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [dpbp_pkg::M_DATA_W-1:0] m_tdata,
	input logic [0:0]                    m_tuser
);

	logic [dpbp_pkg::OUT_W-1:0]   px, py;
	logic [dpbp_pkg::DEPTH_W-1:0] pz;
	logic                         x_rail, y_rail;

	assign px = m_tdata[dpbp_pkg::OUT_W-1:0];
	assign py = m_tdata[2*dpbp_pkg::OUT_W-1:dpbp_pkg::OUT_W];
	assign pz = m_tdata[2*dpbp_pkg::OUT_W+dpbp_pkg::DEPTH_W-1:2*dpbp_pkg::OUT_W];
	assign x_rail = (px == dpbp_pkg::OUT_POS_MAX) || (px == dpbp_pkg::OUT_NEG_MIN);
	assign y_rail = (py == dpbp_pkg::OUT_POS_MAX) || (py == dpbp_pkg::OUT_NEG_MIN);

	// a stalled result stays offered and unchanged
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// clipped item has x or y on a rail
	`ASSERT_IMPL(a_clip_rail, m_tvalid && m_tuser[0], x_rail || y_rail, "clipped without a saturated coordinate")

	// no measurement projects to the origin
	`ASSERT_IMPL(a_zero_depth, m_tvalid && (pz == '0), (px == '0) && (py == '0) && !m_tuser[0], "zero depth not at origin")

endmodule

bind depth_pixel_back_projection dpbp_checker u_dpbp_checker (.*);

[dv/depth_pixel_back_projection_tb.sv]
// Self-checking testbench for depth_pixel_back_projection: drives depth pixels and
// register writes, and predicts each 3-D point in-house. Depends on dpbp_pkg and the RTL.
`timescale 1ns / 100ps

module depth_pixel_back_projection_tb;

	localparam int LATENCY    = dpbp_pkg::QUO_W / dpbp_pkg::DIV_BITS + 4;
	localparam int MAX_CYCLES = 400000;
	localparam logic signed [63:0] SAT_HI = 64'sd8388607;
	localparam logic signed [63:0] SAT_LO = -64'sd8388608;
	localparam logic [dpbp_pkg::REG_W-1:0] REG_MAX = {dpbp_pkg::REG_W{1'b1}};
	localparam logic [dpbp_pkg::DEPTH_W-1:0] DEPTH_MAX = {dpbp_pkg::DEPTH_W{1'b1}};
	// indexes that map to no register
	localparam logic [dpbp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd4;
	localparam logic [dpbp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

	typedef struct packed {
		logic signed [dpbp_pkg::OUT_W-1:0] x;
		logic signed [dpbp_pkg::OUT_W-1:0] y;
		logic [dpbp_pkg::DEPTH_W-1:0]      z;
		logic                              clipped;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [dpbp_pkg::S_DATA_W-1:0] s_tdata = '0;   // pixel_column, pixel_row, depth_mm, pad
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [dpbp_pkg::M_DATA_W-1:0] m_tdata;        // point_x, point_y, point_z, pad
	logic [0:0] m_tuser;                           // clipped
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [dpbp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [dpbp_pkg::REG_W-1:0] cfg_data = '0;

	// camera intrinsics as the block should hold them
	logic [dpbp_pkg::REG_W-1:0] focal_x = dpbp_pkg::FOCAL_X_RST;
	logic [dpbp_pkg::REG_W-1:0] focal_y = dpbp_pkg::FOCAL_Y_RST;
	logic [dpbp_pkg::REG_W-1:0] center_x = dpbp_pkg::CENTER_X_RST;
	logic [dpbp_pkg::REG_W-1:0] center_y = dpbp_pkg::CENTER_Y_RST;

	point_t expected_points[$];
	int error_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int sink_idle_pct = 0;
	int sink_stall = 0;

	depth_pixel_back_projection dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == MAX_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// one axis: ((pix << 8) - center) * depth / focal, truncated, saturated
	function automatic logic signed [dpbp_pkg::OUT_W-1:0] axis_coord(
			input logic [dpbp_pkg::PIX_W-1:0] pix,
			input logic [dpbp_pkg::REG_W-1:0] center,
			input logic [dpbp_pkg::DEPTH_W-1:0] depth,
			input logic [dpbp_pkg::REG_W-1:0] focal, output logic sat);
		longint offset;
		longint num;
		longint quo;
		offset = longint'({pix, 8'b0}) - longint'(center);
		num = offset * longint'(depth);
		sat = 1'b0;
		if (focal == 0) begin
			// zero focal length: sign of the numerator picks the rail
			if (num > 0) quo = SAT_HI + 1;
			else if (num < 0) quo = SAT_LO - 1;
			else quo = 0;
		end else begin
			quo = num / longint'(focal);
		end
		if (quo > SAT_HI) begin
			sat = 1'b1;
			quo = SAT_HI;
		end else if (quo < SAT_LO) begin
			sat = 1'b1;
			quo = SAT_LO;
		end
		return quo[dpbp_pkg::OUT_W-1:0];
	endfunction

	function automatic point_t project_pixel(input logic [dpbp_pkg::PIX_W-1:0] col,
			input logic [dpbp_pkg::PIX_W-1:0] row,
			input logic [dpbp_pkg::DEPTH_W-1:0] depth);
		point_t p;
		logic sat_x;
		logic sat_y;
		p.x = axis_coord(col, center_x, depth, focal_x, sat_x);
		p.y = axis_coord(row, center_y, depth, focal_y, sat_y);
		p.z = depth;
		p.clipped = sat_x | sat_y;
		return p;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("ERROR cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
		error_count++;
	endtask

	// result checker
	always @(posedge clk) begin : check_points
		point_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_points.size() == 0) begin
				report_mismatch("result with none pending", 0, 0);
			end else begin
				want = expected_points.pop_front();
				if (m_tdata[dpbp_pkg::OUT_W-1:0] !== want.x)
					report_mismatch("point_x",
						longint'($signed(m_tdata[dpbp_pkg::OUT_W-1:0])),
						longint'(want.x));
				if (m_tdata[2*dpbp_pkg::OUT_W-1:dpbp_pkg::OUT_W] !== want.y)
					report_mismatch("point_y",
						longint'($signed(m_tdata[2*dpbp_pkg::OUT_W-1:dpbp_pkg::OUT_W])),
						longint'(want.y));
				if (m_tdata[2*dpbp_pkg::OUT_W+dpbp_pkg::DEPTH_W-1:2*dpbp_pkg::OUT_W]
						!== want.z)
					report_mismatch("point_z",
						longint'(m_tdata[2*dpbp_pkg::OUT_W+dpbp_pkg::DEPTH_W-1:
							2*dpbp_pkg::OUT_W]),
						longint'(want.z));
				if (m_tuser[0] !== want.clipped)
					report_mismatch("clipped", longint'(m_tuser[0]), longint'(want.clipped));
			end
		end
	end

	// result side drops ready in bursts of random length
	always @(posedge clk) begin
		if (sink_stall != 0) begin
			sink_stall <= sink_stall - 1;
			m_tready <= 1'b0;
		end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
			sink_stall <= $urandom_range(0, 10);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// send one depth pixel; valid stays high after the handshake
	task automatic send_pixel(input logic [dpbp_pkg::PIX_W-1:0] col,
			input logic [dpbp_pkg::PIX_W-1:0] row,
			input logic [dpbp_pkg::DEPTH_W-1:0] depth);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= dpbp_pkg::S_DATA_W'({depth, row, col});
		do @(posedge clk); while (!s_tready);
		expected_points.push_back(project_pixel(col, row, depth));
	endtask

	// stop sending and wait for every pending point
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [dpbp_pkg::CFG_IDX_W-1:0] idx,
			input logic [dpbp_pkg::REG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			dpbp_pkg::REG_FOCAL_X:  focal_x = data;
			dpbp_pkg::REG_FOCAL_Y:  focal_y = data;
			dpbp_pkg::REG_CENTER_X: center_x = data;
			dpbp_pkg::REG_CENTER_Y: center_y = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_intrinsics(input logic [dpbp_pkg::REG_W-1:0] fx,
			input logic [dpbp_pkg::REG_W-1:0] fy,
			input logic [dpbp_pkg::REG_W-1:0] cx,
			input logic [dpbp_pkg::REG_W-1:0] cy);
		write_reg(dpbp_pkg::REG_FOCAL_X, fx);
		write_reg(dpbp_pkg::REG_FOCAL_Y, fy);
		write_reg(dpbp_pkg::REG_CENTER_X, cx);
		write_reg(dpbp_pkg::REG_CENTER_Y, cy);
	endtask

	// defaults after reset: principal point, corners, no measurement
	task automatic test_reset_values();
		send_pixel(12'd640, 12'd480, 20'd16000);
		send_pixel(12'd0, 12'd0, DEPTH_MAX);
		send_pixel(12'hFFF, 12'hFFF, DEPTH_MAX);
		send_pixel(12'd100, 12'd900, 20'd0);
		send_pixel(12'hFFF, 12'd0, 20'd1);
		settle();
	endtask

	// shortest focal length with the principal point at both range ends
	task automatic test_saturation_edges();
		write_intrinsics(20'd256, 20'd256, 20'd0, REG_MAX);
		send_pixel(12'hFFF, 12'd0, DEPTH_MAX);
		send_pixel(12'd0, 12'hFFF, 20'd1000);
		send_pixel(12'd0, 12'd0, 20'd0);
		settle();
	endtask

	// zero focal length: rails by sign, zero numerator stays zero
	task automatic test_zero_focal();
		write_intrinsics(20'd0, 20'd0, dpbp_pkg::CENTER_X_RST, dpbp_pkg::CENTER_Y_RST);
		send_pixel(12'd700, 12'd400, 20'd10);
		send_pixel(12'd640, 12'd480, 20'd500);
		send_pixel(12'd0, 12'hFFF, 20'd0);
		settle();
	endtask

	// writes to unmapped indexes must leave the intrinsics alone
	task automatic test_unmapped_index();
		write_intrinsics(REG_MAX, REG_MAX, REG_MAX, 20'd0);
		write_reg(REG_UNMAPPED_LO, 20'd0);
		write_reg(REG_UNMAPPED_HI, 20'h5A5A5);
		send_pixel(12'd0, 12'hFFF, DEPTH_MAX);
		send_pixel(12'hFFF, 12'd0, DEPTH_MAX);
		settle();
	endtask

	function automatic logic [dpbp_pkg::REG_W-1:0] pick_focal();
		case ($urandom_range(0, 15))
			0: return 20'd0;
			1: return 20'd256;
			2: return REG_MAX;
			3, 4, 5, 6, 7, 8, 9: return dpbp_pkg::REG_W'($urandom_range(64000, 512000));
			default: return dpbp_pkg::REG_W'($urandom_range(256, 20'hFFFFF));
		endcase
	endfunction

	function automatic logic [dpbp_pkg::REG_W-1:0] pick_center();
		case ($urandom_range(0, 9))
			0: return 20'd0;
			1: return REG_MAX;
			default: return dpbp_pkg::REG_W'($urandom_range(0, 20'hFFFFF));
		endcase
	endfunction

	function automatic logic [dpbp_pkg::PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 19))
			0: return 12'd0;
			1: return 12'hFFF;
			default: return dpbp_pkg::PIX_W'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [dpbp_pkg::DEPTH_W-1:0] pick_depth();
		case ($urandom_range(0, 9))
			0: return 20'd0;
			1: return DEPTH_MAX;
			2: return dpbp_pkg::DEPTH_W'($urandom_range(1, 255));
			default: return dpbp_pkg::DEPTH_W'($urandom_range(0, 20'hFFFFF));
		endcase
	endfunction

	// frames of random pixels, new intrinsics per frame; last frame runs flat out
	task automatic test_random_frames();
		for (int frame = 0; frame < 7; frame++) begin
			if (frame == 6) begin
				send_idle_pct = 0;
				sink_idle_pct = 0;
			end else begin
				send_idle_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 40);
				sink_idle_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 40);
			end
			write_intrinsics(pick_focal(), pick_focal(), pick_center(), pick_center());
			for (int n = 0; n < 200; n++) begin
				send_pixel(pick_pixel(), pick_pixel(), pick_depth());
				// occasional full drain mid-frame
				if (frame != 6 && $urandom_range(0, 149) == 0)
					settle();
			end
			settle();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 25;
		sink_idle_pct = 25;
		test_reset_values();
		test_saturation_edges();
		test_zero_focal();
		test_unmapped_index();
		test_random_frames();
		settle();
		repeat (LATENCY + 10) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
